// ===== rtl/lchmc_pkg.sv =====
package lchmc_pkg;

  // Default geometry
  localparam int CAPACITY_DEF = 32;
  localparam int KEY_BITS_DEF = 64;

  // Fixed port widths
  localparam int KEY_W  = 64;
  localparam int SIZE_W = 6;
  localparam int SLOT_W = 5;
  localparam int COST_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
  localparam logic [COST_W-1:0] HIT_COST   = 32'd1;
  localparam logic [COST_W-1:0] MISS_COST  = 32'd5;

  // Flags carried by the scan token from cell to cell
  typedef struct packed {
    logic tok;     // token present at this stage
    logic found;   // a valid entry matched the key
    logic empty;   // an in-use entry is free
    logic victim;  // the oldest valid entry has been seen
  } scan_flags_t;

  // Entry update command broadcast to all cells
  typedef struct packed {
    logic en;       // apply the lookup outcome
    logic miss;     // target entry takes the key
    logic age_all;  // every valid entry ages (fill of a free entry)
    logic flush;    // invalidate everything (size change)
  } upd_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/lchmc_cell.sv =====
module lchmc_cell #(
  parameter int CAPACITY = lchmc_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lchmc_pkg::KEY_BITS_DEF,
  parameter int IDX      = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // broadcast lookup context
  input  logic [KEY_BITS-1:0]      key_i,
  input  logic [$clog2(CAPACITY+1)-1:0] n_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] vic_rank_i,
  // broadcast update command
  input  lchmc_pkg::upd_ctl_t      upd_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] tgt_idx_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] limit_i,
  // scan token from the lower neighbor
  input  lchmc_pkg::scan_flags_t   flags_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] hit_idx_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] hit_rank_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] empty_idx_i,
  input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] vic_idx_i,
  // scan token to the upper neighbor
  output lchmc_pkg::scan_flags_t   flags_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] hit_idx_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] hit_rank_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] empty_idx_o,
  output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] vic_idx_o,
  output logic                     valid_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY+1);
  localparam logic [IW-1:0] MY_IDX   = IW'(IDX);
  localparam logic [IW-1:0] RANK_TOP = IW'(CAPACITY-1);

  logic [KEY_BITS-1:0] tag_r, tag_nxt;
  logic                valid_r, valid_nxt;
  logic [IW-1:0]       rank_r, rank_nxt;

  lchmc_pkg::scan_flags_t flags_r, flags_nxt;
  logic [IW-1:0] hit_idx_r, hit_idx_nxt;
  logic [IW-1:0] hit_rank_r, hit_rank_nxt;
  logic [IW-1:0] empty_idx_r, empty_idx_nxt;
  logic [IW-1:0] vic_idx_r, vic_idx_nxt;

  logic in_use, match, hole, oldest, is_tgt;

  // Local view of this entry
  assign in_use = NW'(IDX) < n_i;
  assign match  = valid_r && in_use && (tag_r == key_i);
  assign hole   = in_use && !valid_r;
  assign oldest = valid_r && in_use && (rank_r == vic_rank_i);
  assign is_tgt = in_use && (MY_IDX == tgt_idx_i);

  // Merge local result into the passing token; lower index keeps priority
  always_comb begin
    flags_nxt.tok    = flags_i.tok;
    flags_nxt.found  = flags_i.found  || match;
    flags_nxt.empty  = flags_i.empty  || hole;
    flags_nxt.victim = flags_i.victim || oldest;
    hit_idx_nxt   = flags_i.found  ? hit_idx_i   : MY_IDX;
    hit_rank_nxt  = flags_i.found  ? hit_rank_i  : rank_r;
    empty_idx_nxt = flags_i.empty  ? empty_idx_i : MY_IDX;
    vic_idx_nxt   = flags_i.victim ? vic_idx_i   : MY_IDX;
  end

  // Apply flush or lookup outcome to the entry
  always_comb begin
    tag_nxt   = tag_r;
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    if (upd_i.flush) begin
      valid_nxt = 1'b0;
      rank_nxt  = '0;
    end else if (upd_i.en) begin
      if (is_tgt) begin
        rank_nxt = '0;
        if (upd_i.miss) begin
          valid_nxt = 1'b1;
          tag_nxt   = key_i;
        end
      end else if (valid_r && in_use && (upd_i.age_all || (rank_r < limit_i)) &&
                   (rank_r != RANK_TOP)) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
      flags_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      flags_r <= flags_nxt;
    end
  end

  // Advance token payload and hold the tag
  always_ff @(posedge clk) begin
    tag_r       <= tag_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_rank_r  <= hit_rank_nxt;
    empty_idx_r <= empty_idx_nxt;
    vic_idx_r   <= vic_idx_nxt;
  end

  assign flags_o     = flags_r;
  assign hit_idx_o   = hit_idx_r;
  assign hit_rank_o  = hit_rank_r;
  assign empty_idx_o = empty_idx_r;
  assign vic_idx_o   = vic_idx_r;
  assign valid_o     = valid_r;

endmodule

// ===== rtl/lru_cache_hit_miss_cost_top.sv =====
// Fully associative LRU cache lookup with a running access cost.
//
// Input channel (in_valid/in_ready/in_key): one lookup request per key.
// Result channel (out_valid/out_ready): hit flag, slot hit or filled, and the
// saturating total cost after this request (hit adds 1, miss adds 5).
// Configuration: cfg_wr_en with cfg_cache_size sets the number of entries in
// use and invalidates all entries; the cost is kept. Write only while idle.
//
// Each request is handled in steps: a scan token walks the row of entry cells,
// one cell per cycle, collecting the match, the first free entry and the
// oldest entry; the update step then updates all cells and the cost, and the
// result then moves to the output register. One request is in flight at a
// time: a new request is accepted only after the result of the last one has
// moved to the output register.
// When the receiver stalls, the result waits in the output register and the
// next request is still accepted and scanned; it then waits until the output
// register frees up.
// Reset (rst_n low, synchronous) invalidates all entries, clears the cost and
// sets the size to 32.
module lru_cache_hit_miss_cost_top #(
  parameter int CAPACITY = lchmc_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = lchmc_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lchmc_pkg::KEY_W-1:0]   in_key,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [lchmc_pkg::SLOT_W-1:0]  out_slot,
  output logic [lchmc_pkg::COST_W-1:0]  out_total_cost,
  input  logic                          cfg_wr_en,
  input  logic [lchmc_pkg::SIZE_W-1:0]  cfg_cache_size
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY+1);
  localparam int CW = (NW > lchmc_pkg::SIZE_W) ? NW : lchmc_pkg::SIZE_W;
  localparam int LAST = CAPACITY;

  lchmc_pkg::state_t state_r, state_nxt;

  logic [lchmc_pkg::SIZE_W-1:0] size_r;
  logic [KEY_BITS-1:0]          key_r;
  logic                         start_r;
  logic [lchmc_pkg::COST_W-1:0] cost_r, cost_nxt;
  logic                         res_hit_r;
  logic [IW-1:0]                res_slot_r;
  logic [lchmc_pkg::COST_W-1:0] res_cost_r;
  logic                         out_valid_r;
  logic                         out_hit_r;
  logic [lchmc_pkg::SLOT_W-1:0] out_slot_r;
  logic [lchmc_pkg::COST_W-1:0] out_cost_r;

  logic [CW-1:0] size_ext;
  logic [NW-1:0] n_use;
  logic [IW-1:0] vic_rank;
  logic          n_zero;

  logic accept, do_update, load_out, out_free, last_tok;

  lchmc_pkg::upd_ctl_t upd;
  logic [IW-1:0]       tgt_idx, limit;
  logic                sel_hit;
  logic [lchmc_pkg::COST_W:0] cost_sum;

  // Scan chain: index 0 feeds cell 0, index i+1 is the output of cell i
  lchmc_pkg::scan_flags_t flags_w [CAPACITY+1];
  logic [IW-1:0] hit_idx_w   [CAPACITY+1];
  logic [IW-1:0] hit_rank_w  [CAPACITY+1];
  logic [IW-1:0] empty_idx_w [CAPACITY+1];
  logic [IW-1:0] vic_idx_w   [CAPACITY+1];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] tok_vec;

  // Entries in use, clipped to capacity
  assign size_ext = CW'(size_r);
  assign n_use    = (size_ext > CW'(CAPACITY)) ? NW'(CAPACITY) : NW'(size_ext);
  assign n_zero   = (n_use == '0);
  assign vic_rank = IW'(n_use - 1'b1);

  // Launch the token into cell 0
  assign flags_w[0]     = '{tok: start_r, found: 1'b0, empty: 1'b0, victim: 1'b0};
  assign hit_idx_w[0]   = '0;
  assign hit_rank_w[0]  = '0;
  assign empty_idx_w[0] = '0;
  assign vic_idx_w[0]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lchmc_cell #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS),
      .IDX      (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .key_i       (key_r),
      .n_i         (n_use),
      .vic_rank_i  (vic_rank),
      .upd_i       (upd),
      .tgt_idx_i   (tgt_idx),
      .limit_i     (limit),
      .flags_i     (flags_w[i]),
      .hit_idx_i   (hit_idx_w[i]),
      .hit_rank_i  (hit_rank_w[i]),
      .empty_idx_i (empty_idx_w[i]),
      .vic_idx_i   (vic_idx_w[i]),
      .flags_o     (flags_w[i+1]),
      .hit_idx_o   (hit_idx_w[i+1]),
      .hit_rank_o  (hit_rank_w[i+1]),
      .empty_idx_o (empty_idx_w[i+1]),
      .vic_idx_o   (vic_idx_w[i+1]),
      .valid_o     (valid_vec[i])
    );
    assign tok_vec[i] = flags_w[i+1].tok;
  end

  assign last_tok = flags_w[LAST].tok;
  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lchmc_pkg::ST_IDLE: if (in_valid) state_nxt = lchmc_pkg::ST_SCAN;
      lchmc_pkg::ST_SCAN: if (last_tok) state_nxt = lchmc_pkg::ST_EMIT;
      lchmc_pkg::ST_EMIT: if (out_free) state_nxt = lchmc_pkg::ST_IDLE;
      default:            state_nxt = lchmc_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready  = 1'b0;
    do_update = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      lchmc_pkg::ST_IDLE: in_ready  = 1'b1;
      lchmc_pkg::ST_SCAN: do_update = last_tok;
      lchmc_pkg::ST_EMIT: load_out  = out_free;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Pick the outcome from the token at the end of the row
  always_comb begin
    sel_hit     = 1'b0;
    tgt_idx     = '0;
    limit       = '0;
    upd.miss    = 1'b1;
    upd.age_all = 1'b0;
    priority if (n_zero) begin
      tgt_idx = '0;
    end else if (flags_w[LAST].found) begin
      sel_hit  = 1'b1;
      upd.miss = 1'b0;
      tgt_idx  = hit_idx_w[LAST];
      limit    = hit_rank_w[LAST];
    end else if (flags_w[LAST].empty) begin
      tgt_idx     = empty_idx_w[LAST];
      upd.age_all = 1'b1;
    end else begin
      tgt_idx = vic_idx_w[LAST];
      limit   = vic_rank;
    end
    upd.en    = do_update && !n_zero;
    upd.flush = cfg_wr_en;
  end

  // Saturating cost add
  always_comb begin
    cost_sum = {1'b0, cost_r} + {1'b0, (sel_hit ? lchmc_pkg::HIT_COST : lchmc_pkg::MISS_COST)};
    cost_nxt = cost_sum[lchmc_pkg::COST_W] ? '1 : cost_sum[lchmc_pkg::COST_W-1:0];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lchmc_pkg::ST_IDLE;
      start_r     <= 1'b0;
      size_r      <= lchmc_pkg::SIZE_RESET;
      cost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= accept;
      if (cfg_wr_en) size_r <= cfg_cache_size;
      if (do_update) cost_r <= cost_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) key_r <= in_key[KEY_BITS-1:0];
    if (do_update) begin
      res_hit_r  <= sel_hit;
      res_slot_r <= tgt_idx;
      res_cost_r <= cost_nxt;
    end
    if (load_out) begin
      out_hit_r  <= res_hit_r;
      out_slot_r <= lchmc_pkg::SLOT_W'(res_slot_r);
      out_cost_r <= res_cost_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_slot       = out_slot_r;
  assign out_total_cost = out_cost_r;

`ifndef SYNTHESIS
  // At most one token travels the row
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vec))
    else $error("more than one scan token in the cell row");

  // A full scan always finds a hit, a free entry or the oldest entry
  a_scan_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (do_update && !n_zero) |->
      (flags_w[LAST].found || flags_w[LAST].empty || flags_w[LAST].victim))
    else $error("scan ended without a target entry");

  // Valid entries never outnumber the entries in use
  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) <= int'(n_use))
    else $error("more valid entries than entries in use");
`endif

endmodule

// ===== bench/lru_lookup_checker.sv =====
`timescale 1ns / 100ps

module lru_lookup_checker #(
  parameter int CAPACITY = lchmc_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [lchmc_pkg::KEY_W-1:0]   in_key,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic                          out_hit,
  input  logic [lchmc_pkg::SLOT_W-1:0]  out_slot,
  input  logic [lchmc_pkg::COST_W-1:0]  out_total_cost,
  input  logic                          cfg_wr_en,
  input  logic [lchmc_pkg::SIZE_W-1:0]  cfg_cache_size,
  output int                            fail_count,
  output int                            pending,
  output int                            hit_count,
  output int                            miss_count
);

  localparam int KEY_W  = lchmc_pkg::KEY_W;
  localparam int SLOT_W = lchmc_pkg::SLOT_W;
  localparam int COST_W = lchmc_pkg::COST_W;
  localparam int SIZE_W = lchmc_pkg::SIZE_W;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [COST_W-1:0] cost;
  } lookup_result_t;

  // Shadow copy of the cache contents
  logic [KEY_W-1:0]  tag_mem   [CAPACITY];
  logic              tag_valid [CAPACITY];
  logic [SLOT_W-1:0] age_rank  [CAPACITY];
  logic [COST_W-1:0] cost_total;
  logic [SIZE_W-1:0] size_reg;

  lookup_result_t expected_lookups[$];

  function automatic void flush_cache();
    for (int i = 0; i < CAPACITY; i++) begin
      tag_valid[i] = 1'b0;
      age_rank[i]  = '0;
    end
  endfunction

  function automatic logic [COST_W-1:0] add_cost(logic [COST_W-1:0] sum,
                                                 logic [COST_W-1:0] amount);
    logic [COST_W-1:0] top;
    top = {COST_W{1'b1}};
    return (sum > top - amount) ? top : sum + amount;
  endfunction

  // Age every valid in-use entry younger than limit, saturating at the oldest rank
  function automatic void age_entries(int ways, int limit);
    for (int i = 0; i < ways; i++) begin
      if (tag_valid[i] && int'(age_rank[i]) < limit && int'(age_rank[i]) < CAPACITY - 1)
        age_rank[i] = age_rank[i] + 1'b1;
    end
  endfunction

  function automatic lookup_result_t predict_lookup(logic [KEY_W-1:0] key);
    lookup_result_t res;
    int ways, slot, oldest;
    bit found, empty;
    res = '0;
    slot = 0;
    oldest = 0;
    found = 1'b0;
    empty = 1'b0;
    ways = (int'(size_reg) > CAPACITY) ? CAPACITY : int'(size_reg);
    if (ways == 0) begin
      // No entries in use: always a miss on slot zero, nothing stored
      cost_total = add_cost(cost_total, lchmc_pkg::MISS_COST);
    end else begin
      // Scan downward so the lowest matching index wins
      for (int i = ways - 1; i >= 0; i--) begin
        if (tag_valid[i] && tag_mem[i] == key) begin
          found = 1'b1;
          slot = i;
        end
      end
      if (found) begin
        age_entries(ways, int'(age_rank[slot]));
        age_rank[slot] = '0;
        cost_total = add_cost(cost_total, lchmc_pkg::HIT_COST);
      end else begin
        for (int i = ways - 1; i >= 0; i--) begin
          if (!tag_valid[i]) begin
            empty = 1'b1;
            slot = i;
          end
        end
        if (empty) begin
          age_entries(ways, CAPACITY);
        end else begin
          // Evict the oldest entry; strict compare keeps the lowest index on a tie
          for (int i = 0; i < ways; i++) begin
            if (int'(age_rank[i]) > oldest) begin
              oldest = int'(age_rank[i]);
              slot = i;
            end
          end
          age_entries(ways, oldest);
        end
        tag_mem[slot]   = key;
        tag_valid[slot] = 1'b1;
        age_rank[slot]  = '0;
        cost_total = add_cost(cost_total, lchmc_pkg::MISS_COST);
      end
    end
    res.hit  = found;
    res.slot = slot[SLOT_W-1:0];
    res.cost = cost_total;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (fail_count < PRINT_LIMIT)
      $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // Watch both channels and the register port at every rising edge
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      flush_cache();
      cost_total = '0;
      size_reg = lchmc_pkg::SIZE_RESET;
      expected_lookups.delete();
      fail_count = 0;
      hit_count = 0;
      miss_count = 0;
    end else begin
      // Compare a delivered result with the oldest outstanding request
      if (out_valid && out_ready) begin
        if (expected_lookups.size() == 0) begin
          report_mismatch("result with no request outstanding", out_total_cost, 0);
        end else begin
          want = expected_lookups.pop_front();
          if (out_hit != want.hit)
            report_mismatch("hit", out_hit, want.hit);
          if (out_slot != want.slot)
            report_mismatch("slot", out_slot, want.slot);
          if (out_total_cost != want.cost)
            report_mismatch("total_cost", out_total_cost, want.cost);
        end
      end
      // Resize and invalidate; the cost is kept
      if (cfg_wr_en) begin
        size_reg = cfg_cache_size;
        flush_cache();
      end
      // Predict each accepted request
      if (in_valid && in_ready) begin
        want = predict_lookup(in_key);
        expected_lookups.push_back(want);
        if (want.hit)
          hit_count++;
        else
          miss_count++;
      end
    end
    pending = expected_lookups.size();
  end

endmodule

// ===== bench/lru_cache_hit_miss_cost_top_test.sv =====
`timescale 1ns / 100ps

module lru_cache_hit_miss_cost_top_test;

  localparam int CAPACITY    = lchmc_pkg::CAPACITY_DEF;
  localparam int KEY_W       = lchmc_pkg::KEY_W;
  localparam int SIZE_W      = lchmc_pkg::SIZE_W;
  localparam int SLOT_W      = lchmc_pkg::SLOT_W;
  localparam int COST_W      = lchmc_pkg::COST_W;
  localparam int LATENCY     = CAPACITY + 3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENT_LEN = 70;
  localparam int NUM_SEGMENTS = 12;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [KEY_W-1:0]  in_key;
  logic              out_valid;
  logic              out_ready;
  logic              out_hit;
  logic [SLOT_W-1:0] out_slot;
  logic [COST_W-1:0] out_total_cost;
  logic              cfg_wr_en;
  logic [SIZE_W-1:0] cfg_cache_size;

  int fail_count;
  int pending;
  int hit_count;
  int miss_count;
  int send_gap_pct;
  int recv_stall_pct;
  int cycle_count;
  int sizes_used;

  lru_cache_hit_miss_cost_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_slot       (out_slot),
    .out_total_cost (out_total_cost),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_cache_size (cfg_cache_size)
  );

  lru_lookup_checker #(.CAPACITY(CAPACITY)) result_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_key         (in_key),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_slot       (out_slot),
    .out_total_cost (out_total_cost),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_cache_size (cfg_cache_size),
    .fail_count     (fail_count),
    .pending        (pending),
    .hit_count      (hit_count),
    .miss_count     (miss_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Stall the result channel at random
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding", cycle_count, pending);
      $display("lru_cache_hit_miss_cost_top test failed");
      $finish;
    end
  end

  // Present one request, idling first at random; call and return at a falling edge
  task automatic send_key(input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_key = key;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drain all requests, let the block settle, then resize
  task automatic write_size(input logic [SIZE_W-1:0] value);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_cache_size = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sizes_used++;
  endtask

  // Random traffic over a working set a bit larger than the cache
  task automatic run_segment(input logic [SIZE_W-1:0] size, input int count);
    logic [KEY_W-1:0] pool[$];
    logic [KEY_W-1:0] key;
    int ways, pick, sweep;
    write_size(size);
    ways = (int'(size) > CAPACITY) ? CAPACITY : int'(size);
    sweep = 0;
    for (int i = 0; i < ways + ways / 4 + 3; i++)
      pool.push_back({$urandom, $urandom});
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        key = pool[$urandom_range(pool.size() - 1)];
      end else if (pick < 80) begin
        // walk the pool in order to exercise eviction of the oldest entry
        key = pool[sweep % pool.size()];
        sweep++;
      end else if (pick < 88) begin
        // one bit away from a cached tag
        key = pool[$urandom_range(pool.size() - 1)] ^ (64'd1 << $urandom_range(KEY_W - 1));
      end else if (pick < 90) begin
        key = '0;
      end else if (pick < 92) begin
        key = '1;
      end else begin
        key = {$urandom, $urandom};
      end
      send_key(key);
    end
  endtask

  initial begin
    logic [KEY_W-1:0] k1, k2, k3;
    logic [SIZE_W-1:0] seg_sizes[NUM_SEGMENTS];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_key = '0;
    cfg_wr_en = 1'b0;
    cfg_cache_size = '0;
    send_gap_pct = 12;
    recv_stall_pct = 55;
    cycle_count = 0;
    sizes_used = 0;
    seg_sizes = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd5, 6'd33, 6'd17, 6'd2, 6'd8, 6'd31, 6'd3, 6'd24};
    k1 = {$urandom, $urandom};
    k2 = {$urandom, $urandom};
    k3 = {$urandom, $urandom};
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Reset size: key extremes, then hits on them
    send_key('0);
    send_key('1);
    send_key({32{2'b10}});
    send_key({32{2'b01}});
    send_key('0);
    send_key('1);

    // Two ways: fill, hit, evict the least recent twice
    write_size(6'd2);
    send_key(k1);
    send_key(k2);
    send_key(k1);
    send_key(k3);
    send_key(k2);
    send_key(k3);

    // One way: the only entry is always the victim
    write_size(6'd1);
    send_key(k1);
    send_key(k1);
    send_key(k2);

    // Zero ways: every request misses on slot zero
    write_size(6'd0);
    send_key(k1);
    send_key(k1);

    // Size beyond capacity behaves as full capacity
    write_size(6'd40);
    send_key(k1);
    send_key(k1);
    send_key(k2);

    // Random traffic in three phases of idling: receiver-heavy, sender-heavy, then none
    for (int s = 0; s < NUM_SEGMENTS; s++) begin
      if (s == NUM_SEGMENTS / 3) begin
        send_gap_pct = 55;
        recv_stall_pct = 12;
      end else if (s == 2 * NUM_SEGMENTS / 3) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      run_segment(seg_sizes[s], SEGMENT_LEN);
    end

    // Drain and settle
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);

    $display("Checked %0d lookups (%0d hits, %0d misses) over %0d cache resizes,",
             hit_count + miss_count, hit_count, miss_count, sizes_used);
    $display("including zero ways, one way and sizes above capacity, under varied stalls.");
    if (fail_count == 0)
      $display("lru_cache_hit_miss_cost_top test passed");
    else
      $display("lru_cache_hit_miss_cost_top test failed");
    $finish;
  end

endmodule
